/* hdl/hcc_pkg.sv */
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types, constants and round functions for the HChaCha20 subkey
// derivation pipeline.
// ----------------------------------------------------------------------------
package hcc_pkg;

  // Sixteen 32-bit state words, word 0 in the low bits.
  typedef logic [15:0][31:0] state_t;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int CFG_INDEX_W       = 8;

  // The constant "expand 32-byte k", loaded little-endian.
  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] KEY_Q0_IDX = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] KEY_Q1_IDX = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] KEY_Q2_IDX = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] KEY_Q3_IDX = 8'd3;

  function automatic logic [31:0] rotl(logic [31:0] v, logic [4:0] n);
    rotl = (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

  // One half of a column or diagonal round: the first half adds and rotates
  // by 16 and 12, the second by 8 and 7. The four quarter rounds touch
  // disjoint words, so the loop only replicates logic.
  function automatic state_t round_half(state_t s, logic diag, logic second);
    state_t      r;
    logic [1:0]  jj;
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] a, b, c, d;
    logic [4:0]  n1, n2;
    r  = s;
    n1 = second ? 5'd8 : 5'd16;
    n2 = second ? 5'd7 : 5'd12;
    for (int j = 0; j < 4; j++) begin
      jj = 2'(j);
      ia = {2'b00, jj};
      ib = {2'b01, jj + (diag ? 2'd1 : 2'd0)};
      ic = {2'b10, jj + (diag ? 2'd2 : 2'd0)};
      id = {2'b11, jj + (diag ? 2'd3 : 2'd0)};
      a  = s[ia] + s[ib];
      d  = rotl(s[id] ^ a, n1);
      c  = s[ic] + d;
      b  = rotl(s[ib] ^ c, n2);
      r[ia] = a;
      r[ib] = b;
      r[ic] = c;
      r[id] = d;
    end
    round_half = r;
  endfunction

endpackage

/* hdl/hcc_cell.sv */
// ----------------------------------------------------------------------------
// hcc_cell
// One pipeline cell: holds a full state word set and applies half of a
// column or diagonal round as the state moves through it.
// ----------------------------------------------------------------------------
module hcc_cell #(
  parameter bit DIAG   = 1'b0,
  parameter bit SECOND = 1'b0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  input  hcc_pkg::state_t up_state,
  output logic            ready,
  input  logic            down_ready,
  output logic            valid,
  output hcc_pkg::state_t state
);

  // The cell takes a new word when empty or when its contents move on.
  assign ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      state <= hcc_pkg::round_half(up_state, DIAG, SECOND);
    end
  end

endmodule

/* hdl/hchacha20_subkey_derive.sv */
// ----------------------------------------------------------------------------
// hchacha20_subkey_derive
// HChaCha20 subkey derivation as a chain of round cells with an output
// register.
// ----------------------------------------------------------------------------
// A result passes through every cell's register and then the output register.
// Throughput: one word per cycle while the output is not stalled; each cell does half a column or diagonal round.
// Reset clears the key registers to zero and empties every cell and the output.
// ----------------------------------------------------------------------------
module hchacha20_subkey_derive #(
  parameter int DOUBLE_ROUNDS = hcc_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [63:0]                     nonce_lo,
  input  logic [63:0]                     nonce_hi,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [63:0]                     subkey_q0,
  output logic [63:0]                     subkey_q1,
  output logic [63:0]                     subkey_q2,
  output logic [63:0]                     subkey_q3,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);

  // Each double round is four cells: the column round split in two halves,
  // then the diagonal round split likewise.
  localparam int STAGES = 4 * DOUBLE_ROUNDS;

  logic [63:0] key_q0, key_q1, key_q2, key_q3;

  logic                   cell_valid [STAGES];
  logic                   cell_ready [STAGES];
  hcc_pkg::state_t        cell_state [STAGES];
  hcc_pkg::state_t        load_state;
  logic                   out_ready;
  hcc_pkg::state_t        fin;

  // Configuration registers. Writes are always taken; an index beyond the
  // four key registers is simply dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_q0 <= '0;
      key_q1 <= '0;
      key_q2 <= '0;
      key_q3 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hcc_pkg::KEY_Q0_IDX: key_q0 <= cfg_data;
        hcc_pkg::KEY_Q1_IDX: key_q1 <= cfg_data;
        hcc_pkg::KEY_Q2_IDX: key_q2 <= cfg_data;
        hcc_pkg::KEY_Q3_IDX: key_q3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Initial state: constant, key and nonce, each 64-bit field split into two
  // little-endian words with the lower half as the lower-numbered word.
  always_comb begin
    load_state[0]  = hcc_pkg::SIGMA0;
    load_state[1]  = hcc_pkg::SIGMA1;
    load_state[2]  = hcc_pkg::SIGMA2;
    load_state[3]  = hcc_pkg::SIGMA3;
    load_state[4]  = key_q0[31:0];
    load_state[5]  = key_q0[63:32];
    load_state[6]  = key_q1[31:0];
    load_state[7]  = key_q1[63:32];
    load_state[8]  = key_q2[31:0];
    load_state[9]  = key_q2[63:32];
    load_state[10] = key_q3[31:0];
    load_state[11] = key_q3[63:32];
    load_state[12] = nonce_lo[31:0];
    load_state[13] = nonce_lo[63:32];
    load_state[14] = nonce_hi[31:0];
    load_state[15] = nonce_hi[63:32];
  end

  // The first cell stalls the input only when it is full and cannot pass its
  // contents on. Bubbles anywhere in the chain close up while the output
  // waits, so input keeps flowing until every cell holds a word.
  assign in_stall = !cell_ready[0];

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    localparam bit DIAG   = ((g % 4) >= 2);
    localparam bit SECOND = ((g % 2) == 1);

    logic            up_valid;
    hcc_pkg::state_t up_state;
    logic            down_ready;

    if (g == 0) begin : g_first
      assign up_valid = in_valid;
      assign up_state = load_state;
    end else begin : g_next
      assign up_valid = cell_valid[g-1];
      assign up_state = cell_state[g-1];
    end

    if (g == STAGES - 1) begin : g_last
      assign down_ready = out_ready;
    end else begin : g_mid
      assign down_ready = cell_ready[g+1];
    end

    hcc_cell #(
      .DIAG   (DIAG),
      .SECOND (SECOND)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (up_valid),
      .up_state   (up_state),
      .ready      (cell_ready[g]),
      .down_ready (down_ready),
      .valid      (cell_valid[g]),
      .state      (cell_state[g])
    );
  end

  // Output register: it holds a finished result steady while the receiver
  // stalls, and separates the chain from the result side.
  assign out_ready = !out_valid || !out_stall;
  assign fin       = cell_state[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= cell_valid[STAGES-1];
    end
  end

  // Only words 0-3 and 12-15 of the final state leave the block; there is no
  // feed-forward addition of the input state.
  always_ff @(posedge clk) begin
    if (out_ready && cell_valid[STAGES-1]) begin
      subkey_q0 <= {fin[1], fin[0]};
      subkey_q1 <= {fin[3], fin[2]};
      subkey_q2 <= {fin[13], fin[12]};
      subkey_q3 <= {fin[15], fin[14]};
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HChaCha20 subkey derivation pipeline. Nonce
// words go in through the valid/stall input channel and the key is loaded
// through the configuration write channel. Every subkey word that comes out
// is compared, field by field, with its expected value: the known answer of the
// published vector, or else a behavioural HChaCha20 predictor kept in step with the key registers.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DOUBLE_ROUNDS = 10;
  // Acceptance to result: one register per cell plus the output register.
  localparam int LATENCY       = 4 * DOUBLE_ROUNDS + 1;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_NONCES  = 142;

  // "expand 32-byte k" read as four little-endian words.
  localparam logic [31:0] EXPAND_0 = 32'h6170_7865;
  localparam logic [31:0] EXPAND_1 = 32'h3320_646e;
  localparam logic [31:0] EXPAND_2 = 32'h7962_2d32;
  localparam logic [31:0] EXPAND_3 = 32'h6b20_6574;

  // Indexes that select no key register; writes to them must be ignored.
  localparam logic [hcc_pkg::CFG_INDEX_W-1:0] FIRST_SPARE_IDX = hcc_pkg::KEY_Q3_IDX + 1'b1;
  localparam logic [hcc_pkg::CFG_INDEX_W-1:0] LAST_SPARE_IDX  = '1;

  typedef logic [hcc_pkg::CFG_INDEX_W-1:0] cfg_index_t;

  typedef struct packed {
    logic [63:0] q0;
    logic [63:0] q1;
    logic [63:0] q2;
    logic [63:0] q3;
  } subkey_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        known;    // When set, the subkey below is the answer.
    subkey_t     subkey;
  } nonce_row_t;

  typedef enum int {QUIET, SENDER_GAPS, RECEIVER_STALLS, BOTH_IDLE} idle_mode_e;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [63:0] nonce_lo  = '0;
  logic [63:0] nonce_hi  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] subkey_q0;
  logic [63:0] subkey_q1;
  logic [63:0] subkey_q2;
  logic [63:0] subkey_q3;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [hcc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data  = '0;

  // The key as the predictor sees it, register 0 in element 0.
  logic [3:0][63:0] key_regs = '0;
  subkey_t          pending_subkeys [$];
  int               mismatch_count  = 0;
  int               sender_idle_pct = 0;
  int               recv_stall_pct  = 0;
  nonce_row_t       directed_nonces [14];

  hchacha20_subkey_derive #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .nonce_lo (nonce_lo),
    .nonce_hi (nonce_hi),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .subkey_q0(subkey_q0),
    .subkey_q1(subkey_q1),
    .subkey_q2(subkey_q2),
    .subkey_q3(subkey_q3),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One ChaCha quarter round; the rotations are written out as slices.
  function automatic logic [127:0] quarter_mix(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] c, logic [31:0] d);
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    return {a, b, c, d};
  endfunction

  // HChaCha20: build the state, run the double rounds, keep the first and
  // last rows. There is no feed-forward, so the final words go out as they are.
  function automatic subkey_t hchacha_subkey(logic [3:0][63:0] key, logic [63:0] lo,
                                             logic [63:0] hi);
    logic [15:0][31:0] w;
    logic [3:0]        ia, ib, ic, id;
    int                lane, shift;
    w[0] = EXPAND_0;
    w[1] = EXPAND_1;
    w[2] = EXPAND_2;
    w[3] = EXPAND_3;
    for (int i = 0; i < 4; i++) begin
      w[4 + 2 * i] = key[i][31:0];
      w[5 + 2 * i] = key[i][63:32];
    end
    w[12] = lo[31:0];
    w[13] = lo[63:32];
    w[14] = hi[31:0];
    w[15] = hi[63:32];
    for (int dr = 0; dr < DOUBLE_ROUNDS; dr++) begin
      // Quarter rounds 0-3 work on columns; 4-7 on diagonals, where row r
      // is rotated left by r lanes.
      for (int q = 0; q < 8; q++) begin
        lane  = q % 4;
        shift = q / 4;
        ia = 4'(lane);
        ib = 4'(4 + (lane + shift) % 4);
        ic = 4'(8 + (lane + 2 * shift) % 4);
        id = 4'(12 + (lane + 3 * shift) % 4);
        {w[ia], w[ib], w[ic], w[id]} = quarter_mix(w[ia], w[ib], w[ic], w[id]);
      end
    end
    return '{q0: {w[1], w[0]}, q1: {w[3], w[2]}, q2: {w[13], w[12]}, q3: {w[15], w[14]}};
  endfunction

  // Each 32-bit half is now and then pinned to all zeros or all ones so that
  // the carry chains of the adders also see their extremes.
  function automatic logic [63:0] random_nonce_half();
    logic [63:0] v;
    for (int h = 0; h < 2; h++) begin
      case ($urandom_range(7))
        0:       v[32 * h +: 32] = '0;
        1:       v[32 * h +: 32] = '1;
        default: v[32 * h +: 32] = $urandom;
      endcase
    end
    return v;
  endfunction

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      QUIET:           begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      SENDER_GAPS:     begin sender_idle_pct = 82; recv_stall_pct = 0;  end
      RECEIVER_STALLS: begin sender_idle_pct = 0;  recv_stall_pct = 82; end
      BOTH_IDLE:       begin sender_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the write.
  // cfg_valid is left high so that back-to-back writes need no second
  // assignment in one time step; load_key lowers it.
  task automatic write_key_reg(logic [hcc_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hcc_pkg::KEY_Q0_IDX: key_regs[0] = value;
      hcc_pkg::KEY_Q1_IDX: key_regs[1] = value;
      hcc_pkg::KEY_Q2_IDX: key_regs[2] = value;
      hcc_pkg::KEY_Q3_IDX: key_regs[3] = value;
      default: ;  // No register behind this index.
    endcase
    @(negedge clk);
  endtask

  // Writes the registers picked by the mask, then a write of random data to
  // an index with no register behind it, which must change nothing.
  task automatic load_key(logic [3:0][63:0] value, logic [3:0] mask,
                          logic [hcc_pkg::CFG_INDEX_W-1:0] spare_idx);
    if (mask[0]) write_key_reg(hcc_pkg::KEY_Q0_IDX, value[0]);
    if (mask[1]) write_key_reg(hcc_pkg::KEY_Q1_IDX, value[1]);
    if (mask[2]) write_key_reg(hcc_pkg::KEY_Q2_IDX, value[2]);
    if (mask[3]) write_key_reg(hcc_pkg::KEY_Q3_IDX, value[3]);
    write_key_reg(spare_idx, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high, so a following word can go straight out.
  task automatic send_nonce(logic [63:0] lo, logic [63:0] hi, logic known, subkey_t answer);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      nonce_lo <= {$urandom, $urandom};
      nonce_hi <= {$urandom, $urandom};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    nonce_lo <= lo;
    nonce_hi <= hi;
    do @(posedge clk); while (in_stall);
    // The key cannot change while words are in flight, so the prediction
    // can be made at acceptance.
    pending_subkeys.push_back(known ? answer : hchacha_subkey(key_regs, lo, hi));
    @(negedge clk);
  endtask

  // Stop sending and wait at falling edges until every subkey has arrived.
  // Each nonce yields exactly one result, so the block is idle afterwards.
  task automatic drain_subkeys();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_subkeys.size() != 0) @(negedge clk);
  endtask

  task automatic compare_field(string name, logic [63:0] expected, logic [63:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %h, got %h", name, expected, actual);
      mismatch_count++;
    end
  endtask

  // Receiver back-pressure, redrawn every cycle from the current idle mode.
  always @(negedge clk) begin
    out_stall <= !rst && recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
  end

  // Scoreboard: a word moves when out_valid is high and out_stall is low.
  always @(posedge clk) begin
    subkey_t exp_subkey;
    if (!rst && out_valid && !out_stall) begin
      if (pending_subkeys.size() == 0) begin
        $error("subkey word %h_%h_%h_%h with no nonce outstanding",
               subkey_q3, subkey_q2, subkey_q1, subkey_q0);
        mismatch_count++;
      end else begin
        exp_subkey = pending_subkeys.pop_front();
        compare_field("subkey_q0", exp_subkey.q0, subkey_q0);
        compare_field("subkey_q1", exp_subkey.q1, subkey_q1);
        compare_field("subkey_q2", exp_subkey.q2, subkey_q2);
        compare_field("subkey_q3", exp_subkey.q3, subkey_q3);
      end
    end
  end

  initial begin
    logic [3:0][63:0] key_setting;
    logic [3:0]       key_mask;
    idle_mode_e       mode;

    // Directed nonces. All but one are checked against the predictor; the
    // published HChaCha20 vector (key bytes 00..1f) carries its own answer.
    directed_nonces = '{
      '{64'h0, 64'h0, 1'b0, '0},
      '{'1, '1, 1'b0, '0},
      '{'1, 64'h0, 1'b0, '0},
      '{64'h0, '1, 1'b0, '0},
      '{64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0},
      '{64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0, '0},
      '{64'h0000_0000_0000_0001, 64'h0, 1'b0, '0},
      '{64'h8000_0000_0000_0000, 64'h0, 1'b0, '0},
      '{64'h0, 64'h0000_0000_0000_0001, 1'b0, '0},
      '{64'h0, 64'h8000_0000_0000_0000, 1'b0, '0},
      '{64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000, 1'b0, '0},
      '{64'h4a00_0000_0900_0000, 64'h2759_4131_0000_0000, 1'b1,
        '{q0: 64'hfe7b_b227_423b_4182, q1: 64'h737d_878a_5042_0ed3,
          q2: 64'h53a8_748a_d5e4_f9a0, q3: 64'hdcec_d326_13c4_2ec1}},
      '{64'h4a00_0000_0900_0000, 64'h2759_4131_0000_0000, 1'b0, '0},
      '{64'h8000_0001_8000_0001, 64'h0000_0001_8000_0000, 1'b0, '0}
    };

    // Synchronous reset, released on a falling edge and never raised again.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The key must come out of reset as zero, so the first burst runs with
    // no configuration writes at all.
    set_idling(QUIET);
    repeat (PHASE_NONCES / 4) send_nonce(random_nonce_half(), random_nonce_half(), 1'b0, '0);
    drain_subkeys();

    // Directed part under the counting key of the published vector; the
    // spare write goes to the highest index.
    load_key('{64'h1f1e_1d1c_1b1a_1918, 64'h1716_1514_1312_1110,
               64'h0f0e_0d0c_0b0a_0908, 64'h0706_0504_0302_0100}, 4'b1111, LAST_SPARE_IDX);
    foreach (directed_nonces[r])
      send_nonce(directed_nonces[r].lo, directed_nonces[r].hi,
                 directed_nonces[r].known, directed_nonces[r].subkey);
    drain_subkeys();

    // Random phases walk through every idle mode with keys that include
    // both extremes and partial updates, where only some registers change.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      mode = idle_mode_e'(ph % 4);
      key_mask = 4'b1111;
      case (ph)
        0: key_setting = '1;
        1: key_setting = '0;
        2: key_setting = {4{64'h5555_5555_aaaa_aaaa}};
        3: begin
          key_setting = '{{$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom}};
          key_mask    = 4'b1010;
        end
        default: key_setting = '{{$urandom, $urandom}, {$urandom, $urandom},
                                 {$urandom, $urandom}, {$urandom, $urandom}};
      endcase
      set_idling(mode);
      load_key(key_setting, key_mask,
               cfg_index_t'($urandom_range(LAST_SPARE_IDX, FIRST_SPARE_IDX)));
      repeat (PHASE_NONCES) send_nonce(random_nonce_half(), random_nonce_half(), 1'b0, '0);
      drain_subkeys();
    end

    // Let the pipeline run empty long enough to expose any stray result.
    set_idling(QUIET);
    repeat (LATENCY + 16) @(posedge clk);
    if (pending_subkeys.size() != 0) begin
      $error("%0d subkey words never arrived", pending_subkeys.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
